// File: hw/rtl/ehfp_pkg.sv
// ----------------------------------------------------------------------------
// ehfp_pkg
// Shared types, constants and digit folding for the encoder hex frame parser.
// ----------------------------------------------------------------------------
package ehfp_pkg;

   localparam int VelDigits  = 4;
   localparam int DistDigits = 8;
   localparam int VelCntW    = 3;
   localparam int DistCntW   = 4;
   localparam int VelIdxW    = $clog2(VelDigits);
   localparam int DistIdxW   = $clog2(DistDigits);
   localparam int VelBits    = 16;
   localparam int FoldBits   = 32;

   typedef logic [7:0]                  rx_byte_type;
   typedef logic                        reading_kind_type;
   typedef logic signed [29:0]          reading_value_type;
   typedef logic [VelDigits-1:0][7:0]   vel_chars_type;
   typedef logic [DistDigits-1:0][7:0]  dist_chars_type;

   localparam rx_byte_type IdleByte = 8'hFF;
   localparam rx_byte_type LineFeed = 8'h0A;
   localparam rx_byte_type VelTag   = 8'h56;
   localparam rx_byte_type DistTag  = 8'h44;

   localparam reading_kind_type KindVel  = 1'b0;
   localparam reading_kind_type KindDist = 1'b1;

   // hex digit value; any other byte is taken as a signed char
   function automatic logic [FoldBits-1:0] digit_bits(input rx_byte_type b);
      logic [FoldBits-1:0] d;
      if (b >= 8'd48 && b <= 8'd57) begin
         d = {{(FoldBits-8){1'b0}}, 8'(b - 8'd48)};
      end else if (b >= 8'd65 && b <= 8'd70) begin
         d = {{(FoldBits-8){1'b0}}, 8'(b - 8'd55)};
      end else begin
         d = {{(FoldBits-8){b[7]}}, b};
      end
      return d;
   endfunction

   // shift-and-or chain flattened into an or of shifted digits
   function automatic logic signed [FoldBits-1:0] fold_vel(input vel_chars_type c);
      logic [FoldBits-1:0] acc;
      acc = '0;
      for (int i = 0; i < VelDigits; i++) begin
         acc = acc | (digit_bits(c[i]) << (4 * (VelDigits - 1 - i)));
      end
      return {{(FoldBits-VelBits){acc[VelBits-1]}}, acc[VelBits-1:0]};
   endfunction

   function automatic logic signed [FoldBits-1:0] fold_dist(input dist_chars_type c);
      logic [FoldBits-1:0] acc;
      acc = '0;
      for (int i = 0; i < DistDigits; i++) begin
         acc = acc | (digit_bits(c[i]) << (4 * (DistDigits - 1 - i)));
      end
      return acc;
   endfunction

   // divide by four, rounding toward zero
   function automatic reading_value_type quarter_trunc(input logic signed [FoldBits-1:0] v);
      logic signed [FoldBits-1:0] adj;
      adj = v + (v[FoldBits-1] ? 32'sd3 : 32'sd0);
      return adj[FoldBits-1:2];
   endfunction

endpackage

// File: hw/rtl/ehfp_if.sv
// ----------------------------------------------------------------------------
// ehfp_if
// Valid/ready channels of the encoder hex frame parser.
// ----------------------------------------------------------------------------
interface ehfp_req_if;
   logic                 valid;
   logic                 ready;
   ehfp_pkg::rx_byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ehfp_rsp_if;
   logic                        valid;
   logic                        ready;
   ehfp_pkg::reading_kind_type  reading_kind;
   ehfp_pkg::reading_value_type reading_value;

   modport source (output valid, output reading_kind, output reading_value, input ready);
   modport sink   (input valid, input reading_kind, input reading_value, output ready);
endinterface

// File: hw/rtl/encoder_hex_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// encoder_hex_frame_parser_unit
// Parses velocity and distance hex fields out of a wheel-encoder byte stream.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                      | handshake
//  req_bus  | in  | rx_byte                      | valid/ready
//  rsp_bus  | out | reading_kind, reading_value  | valid/ready
//
//  One byte per cycle unless a stalled result holds the stage; a byte passes
//  the input register, then the parse logic into the result register.
//  Synchronous reset clears the marker, field flags, counts and both valids.
//  A stalled result only holds back a byte that would produce another result;
//  bytes that produce none keep flowing.
// ----------------------------------------------------------------------------
module encoder_hex_frame_parser_unit (
   input  logic       clock,
   input  logic       reset,
   ehfp_req_if.sink   req_bus,
   ehfp_rsp_if.source rsp_bus
);
   import ehfp_pkg::*;

   logic                 byte_valid_ff, byte_valid_in;
   rx_byte_type          byte_ff;
   logic                 armed_ff, armed_in;
   logic                 vel_active_ff, vel_active_in;
   logic                 dist_active_ff, dist_active_in;
   logic [VelCntW-1:0]   vel_cnt_ff, vel_cnt_in;
   logic [DistCntW-1:0]  dist_cnt_ff, dist_cnt_in;
   vel_chars_type        vel_chars_ff, vel_chars_in;
   dist_chars_type       dist_chars_ff, dist_chars_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   reading_kind_type     kind_ff, kind_in;
   reading_value_type    value_ff, value_in;

   logic                 emit;
   logic                 consumed;
   logic                 stage_fire;
   logic                 req_take;

   // parse the registered byte against the current frame state
   always_comb begin
      armed_in       = armed_ff;
      vel_active_in  = vel_active_ff;
      dist_active_in = dist_active_ff;
      vel_cnt_in     = vel_cnt_ff;
      dist_cnt_in    = dist_cnt_ff;
      vel_chars_in   = vel_chars_ff;
      dist_chars_in  = dist_chars_ff;
      emit           = 1'b0;
      consumed       = 1'b0;
      kind_in        = KindVel;
      value_in       = quarter_trunc(fold_vel(vel_chars_in));
      if (byte_ff != IdleByte) begin
         if (byte_ff == LineFeed) begin
            armed_in = 1'b1;
         end else if (armed_ff && byte_ff == VelTag) begin
            vel_active_in = 1'b1;
            vel_cnt_in    = '0;
            armed_in      = 1'b0;
            consumed      = 1'b1;
         end else if (armed_ff && byte_ff == DistTag) begin
            dist_active_in = 1'b1;
            dist_cnt_in    = '0;
            armed_in       = 1'b0;
            consumed       = 1'b1;
         end else if (vel_active_ff) begin
            if (vel_cnt_ff < VelCntW'(VelDigits)) begin
               vel_chars_in[vel_cnt_ff[VelIdxW-1:0]] = byte_ff;
            end
            vel_cnt_in = vel_cnt_ff + 1'b1;
         end else if (dist_active_ff) begin
            if (dist_cnt_ff < DistCntW'(DistDigits)) begin
               dist_chars_in[dist_cnt_ff[DistIdxW-1:0]] = byte_ff;
            end
            dist_cnt_in = dist_cnt_ff + 1'b1;
         end
         if (!consumed) begin
            if (vel_cnt_in == VelCntW'(VelDigits)) begin
               emit          = 1'b1;
               kind_in       = KindVel;
               value_in      = quarter_trunc(fold_vel(vel_chars_in));
               vel_active_in = 1'b0;
               vel_cnt_in    = '0;
            end else if (dist_cnt_in == DistCntW'(DistDigits)) begin
               emit           = 1'b1;
               kind_in        = KindDist;
               value_in       = quarter_trunc(fold_dist(dist_chars_in));
               dist_active_in = 1'b0;
               dist_cnt_in    = '0;
            end
         end
      end
   end

   assign stage_fire     = byte_valid_ff && (!emit || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !byte_valid_ff || stage_fire;
   assign req_take       = req_bus.valid && req_bus.ready;
   assign byte_valid_in  = req_take || (byte_valid_ff && !stage_fire);
   assign rsp_valid_in   = (stage_fire && emit) || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff  <= 1'b0;
         armed_ff       <= 1'b0;
         vel_active_ff  <= 1'b0;
         dist_active_ff <= 1'b0;
         vel_cnt_ff     <= '0;
         dist_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (stage_fire) begin
            armed_ff       <= armed_in;
            vel_active_ff  <= vel_active_in;
            dist_active_ff <= dist_active_in;
            vel_cnt_ff     <= vel_cnt_in;
            dist_cnt_ff    <= dist_cnt_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_bus.rx_byte;
      end
      if (stage_fire) begin
         vel_chars_ff  <= vel_chars_in;
         dist_chars_ff <= dist_chars_in;
      end
      if (stage_fire && emit) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.reading_kind  = kind_ff;
   assign rsp_bus.reading_value = value_ff;

endmodule

// File: hw/rtl/ehfp_checker.sv
// ----------------------------------------------------------------------------
// ehfp_checker
// Port-level checks for the encoder hex frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ehfp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input ehfp_pkg::reading_kind_type  rsp_reading_kind,
   input ehfp_pkg::reading_value_type rsp_reading_value
);
   import ehfp_pkg::*;

   // a result held back by the sink keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reading_kind)
                                  && $stable(rsp_reading_value))
      else $error("stalled result changed");

   // a velocity result comes from a 16-bit field, so it fits in 14 signed bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reading_kind == KindVel |->
         (rsp_reading_value[29:13] == '0 || rsp_reading_value[29:13] == '1))
      else $error("velocity result out of range");

   // nothing is shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the single byte stage always frees up when no result is pending
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) |-> req_ready)
      else $error("input stalled with no result pending");

   // a fresh result needs a byte transferred on the input before it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(!rsp_valid, 2) && !$past(reset, 2) |->
         $past(req_valid && req_ready, 2))
      else $error("result without an input transfer");

endmodule

bind encoder_hex_frame_parser_unit ehfp_checker u_ehfp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_reading_kind  (rsp_bus.reading_kind),
   .rsp_reading_value (rsp_bus.reading_value)
);

// File: tb/tb_encoder_hex_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_hex_frame_parser_unit
// Drives byte streams into the hex frame parser and checks every reading
// against a cycle-free shadow parser. Directed frames hit the value extremes
// and the framing corner cases. Random frames follow, under bursty input and
// a stalling result side.
// ----------------------------------------------------------------------------
module tb_encoder_hex_frame_parser_unit;
   import ehfp_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 8;

   typedef enum int {StallNone, StallRandom, StallPattern} stall_mode_type;

   typedef struct packed {
      reading_kind_type  kind;
      reading_value_type value;
   } reading_type;

   logic clock = 1'b0;
   logic reset;

   ehfp_req_if req_bus ();
   ehfp_rsp_if rsp_bus ();

   encoder_hex_frame_parser_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // shadow parser state
   bit          marker_armed = 1'b0;
   bit          vel_open     = 1'b0;
   bit          dist_open    = 1'b0;
   bit [2:0]    vel_pos      = '0;
   bit [3:0]    dist_pos     = '0;
   rx_byte_type vel_text  [VelDigits];
   rx_byte_type dist_text [DistDigits];

   reading_type    expected_readings [$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             bytes_sent  = 0;
   int             burst_left  = 0;
   bit             sender_gaps = 1'b0;
   stall_mode_type stall_mode  = StallNone;
   int             hold_left   = 0;
   int             stall_phase = 0;

   // hex character value; anything else counts as a signed char
   function automatic logic [31:0] nibble_of(input rx_byte_type c);
      if (c >= "0" && c <= "9") begin
         return 32'(c - "0");
      end else if (c >= "A" && c <= "F") begin
         return 32'(c - "A") + 32'd10;
      end
      return {{24{c[7]}}, c};
   endfunction

   // divide by four, truncating toward zero
   function automatic reading_value_type quarter_of(input longint v);
      return reading_value_type'(v / 4);
   endfunction

   function automatic void parse_byte(input rx_byte_type b);
      logic [15:0] vacc;
      logic [31:0] dacc;
      reading_type r;
      if (b == IdleByte) return;
      if (b == LineFeed) begin
         marker_armed = 1'b1;
      end else if (marker_armed && b == VelTag) begin
         vel_open     = 1'b1;
         vel_pos      = '0;
         marker_armed = 1'b0;
         return;
      end else if (marker_armed && b == DistTag) begin
         dist_open    = 1'b1;
         dist_pos     = '0;
         marker_armed = 1'b0;
         return;
      end else if (vel_open) begin
         if (vel_pos < VelDigits) vel_text[vel_pos] = b;
         vel_pos++;
      end else if (dist_open) begin
         if (dist_pos < DistDigits) dist_text[dist_pos] = b;
         dist_pos++;
      end
      if (vel_pos == VelDigits) begin
         vacc = '0;
         for (int i = 0; i < VelDigits; i++) vacc = (vacc << 4) | 16'(nibble_of(vel_text[i]));
         r.kind  = KindVel;
         r.value = quarter_of(longint'($signed(vacc)));
         expected_readings.push_back(r);
         vel_open = 1'b0;
         vel_pos  = '0;
      end else if (dist_pos == DistDigits) begin
         dacc = '0;
         for (int i = 0; i < DistDigits; i++) dacc = (dacc << 4) | nibble_of(dist_text[i]);
         r.kind  = KindDist;
         r.value = quarter_of(longint'($signed(dacc)));
         expected_readings.push_back(r);
         dist_open = 1'b0;
         dist_pos  = '0;
      end
   endfunction

   function automatic rx_byte_type random_digit();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return rx_byte_type'("0" + r);
      if (r < 16) return rx_byte_type'("A" + r - 10);
      if (r < 18) return rx_byte_type'("a" + $urandom_range(0, 25));
      return rx_byte_type'($urandom);
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input rx_byte_type b);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      parse_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_item(input rx_byte_type b);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= rx_byte_type'($urandom);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      send_byte(b);
   endtask

   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // mostly well-formed frames; some noise, truncated and nested ones
   task automatic send_random_frame();
      int          n_digits;
      int          pick;
      int          fill;
      bit          is_vel;
      bit          nest;
      rx_byte_type b;
      is_vel = $urandom_range(0, 1);
      pick   = $urandom_range(0, 9);
      if (pick == 0) begin
         repeat ($urandom_range(1, 4)) send_item(rx_byte_type'($urandom));
      end else begin
         if ($urandom_range(0, 3) == 0) send_item(IdleByte);
         send_item(LineFeed);
         send_item(is_vel ? VelTag : DistTag);
         n_digits = is_vel ? VelDigits : DistDigits;
         if (pick == 1) n_digits = $urandom_range(0, n_digits - 1);
         nest = (pick == 2) && !is_vel;
         fill = $urandom_range(0, 7);
         for (int i = 0; i < n_digits; i++) begin
            case (fill)
               0: b = (i == 0) ? "8" : "0";
               1: b = (i == 0) ? "7" : "F";
               2: b = "F";
               3: b = "0";
               default: b = random_digit();
            endcase
            // velocity frame inside a distance frame
            if (nest && i == 3) begin
               send_item(LineFeed);
               send_item(VelTag);
               repeat (VelDigits) send_item(random_digit());
            end
            if ($urandom_range(0, 15) == 0) send_item(IdleByte);
            send_item(b);
         end
      end
   endtask

   task automatic send_frames(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) send_random_frame();
   endtask

   task automatic test_field_extremes();
      string s;
      s = "\nV8000\nD7FFFFFFF";
      for (int i = 0; i < s.len(); i++) send_item(s[i]);
      pause_until_drained();
   endtask

   // idle byte mid-field, line feed in data, restart, both fields open,
   // unarmed tag as data, non-hex digits, negative value truncation
   task automatic test_special_cases();
      rx_byte_type seq [$];
      seq = '{LineFeed, DistTag, "1", 8'h00, LineFeed, VelTag, IdleByte, 8'h80, "a",
              LineFeed, VelTag, "F", "F", "F", "B", VelTag, "E", IdleByte, "9", "0",
              "C", "7"};
      foreach (seq[i]) send_item(seq[i]);
      pause_until_drained();
   endtask

   task automatic test_no_idle();
      stall_mode  = StallNone;
      sender_gaps = 1'b0;
      send_frames(100);
      pause_until_drained();
   endtask

   // result side held off while input keeps coming, so the input stalls
   task automatic test_backpressure();
      stall_mode  = StallNone;
      sender_gaps = 1'b0;
      hold_left   = 300;
      send_frames(80);
      stall_mode = StallPattern;
      pause_until_drained();
   endtask

   task automatic test_random_traffic();
      sender_gaps = 1'b1;
      for (int k = 0; k < 6; k++) begin
         case (k % 3)
            0: stall_mode = StallRandom;
            1: stall_mode = StallPattern;
            default: stall_mode = StallNone;
         endcase
         send_frames(100);
      end
      sender_gaps = 1'b0;
      pause_until_drained();
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         case (stall_mode)
            StallRandom: rsp_bus.ready <= ($urandom_range(0, 2) != 0);
            StallPattern: begin
               rsp_bus.ready <= (stall_phase % 7) < 4;
               stall_phase++;
            end
            default: rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected reading kind %0d value %0d", $time,
                     rsp_bus.reading_kind, rsp_bus.reading_value);
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_bus.reading_kind !== want.kind) begin
               $display("%0t: reading_kind expected %0d actual %0d", $time, want.kind,
                        rsp_bus.reading_kind);
               error_count++;
            end
            if (rsp_bus.reading_value !== want.value) begin
               $display("%0t: reading_value expected %0d actual %0d", $time,
                        $signed(want.value), rsp_bus.reading_value);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_encoder_hex_frame_parser_unit: done, errors");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      foreach (vel_text[i]) vel_text[i] = '0;
      foreach (dist_text[i]) dist_text[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_field_extremes();
      test_special_cases();
      test_no_idle();
      test_backpressure();
      test_random_traffic();
      if (error_count == 0) begin
         $display("tb_encoder_hex_frame_parser_unit: done, clean");
      end else begin
         $display("tb_encoder_hex_frame_parser_unit: done, errors");
      end
      $finish;
   end

endmodule
